>>> design/fbat_pkg.sv
// Package: shared types and constants for flow byte accounting.
package fbat_pkg;
  localparam int KEY_W   = 96;
  localparam int BYTES_W = 32;
  localparam int LEN_W   = 16;
  localparam int DROP_W  = 16;
  localparam int RANK_W  = 3;

  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [BYTES_W-1:0] bytes_t;

  // Command broadcast down the chain.
  typedef struct packed {
    logic   acc;     // accumulate a report
    logic   clr;     // clear all cells
    key_t   key;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // Ranked candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic   vld;
    key_t   key;
    bytes_t bytes;
  } cand_t;

  function automatic bytes_t sat_add(bytes_t a, logic [LEN_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {{(BYTES_W+1-LEN_W){1'b0}}, b};
    return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
  endfunction
endpackage

>>> design/fbat_cell.sv
// One flow cell: holds one entry, matches, accumulates, and takes part in the rank scan.
module fbat_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  fbat_pkg::cmd_t     cmd,
  input  logic               claim_in,   // no earlier cell matched or is free
  output logic               claim_out,
  input  logic               shift,      // scan step: cells pass entries toward the head
  input  fbat_pkg::cand_t    nb_in,      // entry from the next cell
  output fbat_pkg::cand_t    st_out,     // this cell's entry
  input  logic               take_best,  // at or after the winner: take the next cell's entry
  output logic               hit
);
  import fbat_pkg::*;

  logic   vld_r, vld_nxt;
  key_t   key_r, key_nxt;
  bytes_t bytes_r, bytes_nxt;

  assign hit       = vld_r && key_r == cmd.key;
  assign claim_out = claim_in && !hit && vld_r;
  assign st_out    = '{vld: vld_r, key: key_r, bytes: bytes_r};

  always_comb begin
    vld_nxt   = vld_r;
    key_nxt   = key_r;
    bytes_nxt = bytes_r;
    priority if (cmd.clr) begin
      vld_nxt = 1'b0;
    end else if (cmd.acc && hit) begin
      bytes_nxt = sat_add(bytes_r, cmd.len);
    end else if (cmd.acc && claim_in && !vld_r) begin
      vld_nxt   = 1'b1;
      key_nxt   = cmd.key;
      bytes_nxt = {{(BYTES_W-LEN_W){1'b0}}, cmd.len};
    end else if (shift && take_best) begin
      vld_nxt   = nb_in.vld;
      key_nxt   = nb_in.key;
      bytes_nxt = nb_in.bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_nxt;
    key_r   <= key_nxt;
    bytes_r <= bytes_nxt;
  end
endmodule

>>> design/fbat_scan.sv
// Rank scan cell: running-best stage of the pipelined compare chain.
module fbat_scan #(
  parameter int IDX_W = 8
) (
  input  logic            clk,
  input  logic [IDX_W-1:0] my_idx,
  input  fbat_pkg::cand_t best_in,
  input  logic [IDX_W-1:0] bidx_in,
  input  fbat_pkg::cand_t mine,
  output fbat_pkg::cand_t best_out,
  output logic [IDX_W-1:0] bidx_out
);
  import fbat_pkg::*;
  logic better;
  // strictly greater wins, so ties keep the earlier entry
  assign better = mine.vld && (!best_in.vld || mine.bytes > best_in.bytes);
  always_ff @(posedge clk) begin
    best_out <= better ? mine : best_in;
    bidx_out <= better ? my_idx : bidx_in;
  end
endmodule

>>> design/flow_byte_accounting_top_k.sv
// Top level: flow byte accounting table with top-k report on tick.
//
// A report transaction compares the key against every cell in parallel, and
// the matching (or first free) cell updates its saturating byte total; busy
// is high for one cycle after start. A tick transaction walks the cell row
// once per rank: a registered best-so-far chain of FLOW_ENTRIES stages runs
// from the head. Results come one per strobe with out_valid, rank ascending,
// last set on the final one; the receiver cannot stall them. A tick with an
// empty table gives no result. The picked entry is removed by compacting the
// row, which keeps claim order.
module flow_byte_accounting_top_k #(
  parameter int FLOW_ENTRIES = 256,
  parameter int TOP_COUNT    = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [31:0]                in_src_addr,
  input  logic [31:0]                in_dst_addr,
  input  logic [15:0]                in_src_port,
  input  logic [15:0]                in_dst_port,
  input  logic [15:0]                in_length,
  output logic                       out_valid,
  output logic [fbat_pkg::RANK_W-1:0] out_rank,
  output logic [31:0]                out_flow_src_addr,
  output logic [31:0]                out_flow_dst_addr,
  output logic [15:0]                out_flow_src_port,
  output logic [15:0]                out_flow_dst_port,
  output logic [31:0]                out_byte_total,
  output logic [15:0]                out_dropped_flows,
  output logic                       out_last
);
  import fbat_pkg::*;

  localparam int IDX_W = $clog2(FLOW_ENTRIES);
  localparam int CNT_W = $clog2(FLOW_ENTRIES+1);
  localparam int RK_W  = $clog2(TOP_COUNT+1);
  localparam int SC_W  = $clog2(FLOW_ENTRIES+2);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]  st_r, st_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [RK_W-1:0] rk_r, rk_nxt;
  logic [SC_W-1:0] sc_r, sc_nxt;
  logic [RK_W-1:0] want;

  logic   [FLOW_ENTRIES:0] claim;
  logic   [FLOW_ENTRIES-1:0] hits, take;
  cand_t  st   [FLOW_ENTRIES];
  cand_t  nb   [FLOW_ENTRIES];
  cand_t  bc   [FLOW_ENTRIES+1];
  logic [IDX_W-1:0] bi [FLOW_ENTRIES+1];
  logic shift;

  assign claim[0] = 1'b1;
  assign bc[0]    = '0;
  assign bi[0]    = '0;

  for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_row
    if (g == FLOW_ENTRIES-1) begin : g_tail
      assign nb[g] = '0;
    end else begin : g_mid
      assign nb[g] = st[g+1];
    end
    // cells at or after the winner shift down by one
    if (g == 0) begin : g_t0
      assign take[g] = (bi[FLOW_ENTRIES] == '0);
    end else begin : g_tn
      assign take[g] = take[g-1] || (bi[FLOW_ENTRIES] == IDX_W'(g));
    end
    fbat_cell u_cell (
      .clk, .rst_n, .cmd(cmd_r), .claim_in(claim[g]), .claim_out(claim[g+1]),
      .shift, .nb_in(nb[g]), .st_out(st[g]), .take_best(take[g]), .hit(hits[g])
    );
    fbat_scan #(.IDX_W(IDX_W)) u_scan (
      .clk, .my_idx(IDX_W'(g)), .best_in(bc[g]), .bidx_in(bi[g]), .mine(st[g]),
      .best_out(bc[g+1]), .bidx_out(bi[g+1])
    );
  end

  assign busy  = (st_r != ST_IDLE);
  assign shift = (st_r == ST_EMIT);
  assign want  = (cnt_r < CNT_W'(TOP_COUNT)) ? RK_W'(cnt_r) : RK_W'(TOP_COUNT);

  always_comb begin
    st_nxt   = st_r;
    cmd_nxt  = cmd_r;
    cmd_nxt.acc = 1'b0;
    cmd_nxt.clr = 1'b0;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    rk_nxt   = rk_r;
    sc_nxt   = sc_r;
    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt.key = {in_src_addr, in_dst_addr, in_src_port, in_dst_port};
          cmd_nxt.len = in_length;
          if (in_mode == MODE_TICK) begin
            rk_nxt = '0;
            sc_nxt = '0;
            if (cnt_r == '0) begin
              cmd_nxt.clr = 1'b1;
              drop_nxt    = '0;
              st_nxt      = ST_ACC;
            end else begin
              st_nxt = ST_SCAN;
            end
          end else begin
            cmd_nxt.acc = 1'b1;
            st_nxt      = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (cmd_r.acc && !(|hits)) begin
          if (claim[FLOW_ENTRIES]) begin
            if (drop_r != '1) drop_nxt = drop_r + 1'b1;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        st_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        sc_nxt = sc_r + 1'b1;
        if (sc_r == SC_W'(FLOW_ENTRIES)) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        rk_nxt = rk_r + 1'b1;
        sc_nxt = '0;
        if (rk_r + 1'b1 == want) begin
          cmd_nxt.clr = 1'b1;
          cnt_nxt     = '0;
          drop_nxt    = '0;
          st_nxt      = ST_ACC;
        end else begin
          st_nxt = ST_SCAN;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      cmd_r  <= '0;
      cnt_r  <= '0;
      drop_r <= '0;
      rk_r   <= '0;
      sc_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      cmd_r  <= cmd_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
      rk_r   <= rk_nxt;
      sc_r   <= sc_nxt;
    end
  end

  assign out_valid         = shift;
  assign out_rank          = RANK_W'(rk_r + 1'b1);
  assign out_flow_src_addr = bc[FLOW_ENTRIES].key[95:64];
  assign out_flow_dst_addr = bc[FLOW_ENTRIES].key[63:32];
  assign out_flow_src_port = bc[FLOW_ENTRIES].key[31:16];
  assign out_flow_dst_port = bc[FLOW_ENTRIES].key[15:0];
  assign out_byte_total    = bc[FLOW_ENTRIES].bytes;
  assign out_dropped_flows = drop_r;
  assign out_last          = shift && (rk_r + 1'b1 == want);
endmodule

>>> design/fbat_checker.sv
// Port-level checker for the flow byte accounting block, bound to the top.
module fbat_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_rank,
  input logic       out_last
);
  a_rank_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rank != 3'd0) else $error("zero rank");
  a_last_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without valid");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid) else $error("result after last");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted start not busy");
endmodule

bind flow_byte_accounting_top_k fbat_checker u_fbat_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_rank, .out_last
);

>>> tb/tb_flow_byte_accounting_top_k.sv
// Testbench for flow_byte_accounting_top_k: directed table, then random intervals.
`timescale 1ns / 1ps

module tb_flow_byte_accounting_top_k;
  import fbat_pkg::*;

  localparam int ENTRIES  = 256;
  localparam int TOPN     = 5;
  localparam int WDOG_MAX = 5000;
  localparam int DRAIN    = 2 * ENTRIES + 20;
  localparam int RAND_ITEMS = 212;   // random intervals run until this many items went out

  // One ranked flow as it shows up on the result ports.
  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [15:0]       sport;
    logic [15:0]       dport;
    logic [31:0]       total;
    logic [15:0]       drops;
    logic              last;
  } ranked_flow_t;

  // Directed stimulus row; has_exp marks rows whose first ranked flow is typed in.
  typedef struct {
    logic         mode;
    logic [31:0]  src;
    logic [31:0]  dst;
    logic [15:0]  sport;
    logic [15:0]  dport;
    logic [15:0]  len;
    bit           has_exp;
    ranked_flow_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = MODE_REPORT;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [15:0] in_length = '0;
  logic out_valid;
  logic [RANK_W-1:0] out_rank;
  logic [31:0] out_flow_src_addr;
  logic [31:0] out_flow_dst_addr;
  logic [15:0] out_flow_src_port;
  logic [15:0] out_flow_dst_port;
  logic [31:0] out_byte_total;
  logic [15:0] out_dropped_flows;
  logic out_last;

  always #10 clk = ~clk;

  flow_byte_accounting_top_k #(.FLOW_ENTRIES(ENTRIES), .TOP_COUNT(TOPN)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_src_addr(in_src_addr), .in_dst_addr(in_dst_addr),
    .in_src_port(in_src_port), .in_dst_port(in_dst_port), .in_length(in_length),
    .out_valid(out_valid), .out_rank(out_rank),
    .out_flow_src_addr(out_flow_src_addr), .out_flow_dst_addr(out_flow_dst_addr),
    .out_flow_src_port(out_flow_src_port), .out_flow_dst_port(out_flow_dst_port),
    .out_byte_total(out_byte_total), .out_dropped_flows(out_dropped_flows),
    .out_last(out_last)
  );

  // ---------------------------------------------------------------------------
  // Shadow flow table. Entries are claimed in index order, so entry i holds a
  // flow exactly when i < flow_cnt; entries past flow_cnt are never read.
  // ---------------------------------------------------------------------------
  key_t         flow_key[ENTRIES];
  bytes_t       flow_bytes[ENTRIES];
  int           flow_cnt = 0;
  logic [15:0]  drop_cnt = '0;
  ranked_flow_t pending_ranks[$];   // expected ranked flows, oldest first

  int  mismatches = 0;
  bit  failed = 1'b0;
  int  idle_cycles = 0;
  int  n_sent = 0;

  // Report transaction: hit accumulates with saturation, miss claims the next
  // free entry, miss on a full table bumps the saturating drop count.
  function automatic void account_flow(key_t k, logic [15:0] len);
    logic [32:0] sum;
    for (int i = 0; i < flow_cnt; i++) begin
      if (flow_key[i] == k) begin
        sum = {1'b0, flow_bytes[i]} + 33'(len);
        flow_bytes[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        return;
      end
    end
    if (flow_cnt < ENTRIES) begin
      flow_key[flow_cnt]   = k;
      flow_bytes[flow_cnt] = 32'(len);
      flow_cnt++;
    end else if (drop_cnt != 16'hFFFF) begin
      drop_cnt++;
    end
  endfunction

  // Tick transaction: queue the top flows (ties go to the lower index), mark
  // the final one, then clear the interval.
  function automatic void rank_top_flows(ref ranked_flow_t picks[$]);
    bit           taken[ENTRIES];
    int           best;
    int           want;
    ranked_flow_t rf;
    want = (flow_cnt < TOPN) ? flow_cnt : TOPN;
    picks.delete();
    for (int i = 0; i < ENTRIES; i++) taken[i] = 1'b0;
    for (int r = 0; r < want; r++) begin
      best = -1;
      for (int i = 0; i < flow_cnt; i++)
        if (!taken[i] && (best < 0 || flow_bytes[i] > flow_bytes[best])) best = i;
      taken[best] = 1'b1;
      rf.rank  = RANK_W'(r + 1);
      {rf.src, rf.dst, rf.sport, rf.dport} = flow_key[best];
      rf.total = flow_bytes[best];
      rf.drops = drop_cnt;
      rf.last  = (r == want - 1);
      picks = {picks, rf};
    end
    flow_cnt = 0;
    drop_cnt = '0;
  endfunction

  // Drive one transaction and hold it until the block takes it, then predict.
  task automatic send_txn(input logic m, input logic [31:0] s, input logic [31:0] d,
                          input logic [15:0] sp, input logic [15:0] dp,
                          input logic [15:0] len, output ranked_flow_t picks[$]);
    start       <= 1'b1;
    in_mode     <= m;
    in_src_addr <= s;
    in_dst_addr <= d;
    in_src_port <= sp;
    in_dst_port <= dp;
    in_length   <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    picks.delete();
    if (m == MODE_TICK) rank_top_flows(picks);
    else account_flow({s, d, sp, dp}, len);
    foreach (picks[i]) pending_ranks = {pending_ranks, picks[i]};
  endtask

  // Sender idle after an accepted transaction; zero keeps start high.
  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic bit same_flow(ranked_flow_t a, ranked_flow_t b);
    return a.rank == b.rank && a.src == b.src && a.dst == b.dst &&
           a.sport == b.sport && a.dport == b.dport && a.total == b.total &&
           a.drops == b.drops && a.last == b.last;
  endfunction

  function automatic void note_mismatch(string what, ranked_flow_t e, ranked_flow_t a);
    failed = 1'b1;
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp r%0d %h %h %h %h tot %h drop %h last %b | got r%0d %h %h %h %h tot %h drop %h last %b",
               $realtime, what, e.rank, e.src, e.dst, e.sport, e.dport, e.total, e.drops, e.last,
               a.rank, a.src, a.dst, a.sport, a.dport, a.total, a.drops, a.last);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest expected ranked flow.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ranked_flow_t got;
    ranked_flow_t exp;
    if (rst_n && out_valid) begin
      got.rank  = out_rank;
      got.src   = out_flow_src_addr;
      got.dst   = out_flow_dst_addr;
      got.sport = out_flow_src_port;
      got.dport = out_flow_dst_port;
      got.total = out_byte_total;
      got.drops = out_dropped_flows;
      got.last  = out_last;
      if (pending_ranks.size() == 0) begin
        exp = '{default: '0};
        note_mismatch("unexpected result", exp, got);
      end else begin
        exp = pending_ranks.pop_front();
        if (!same_flow(exp, got)) note_mismatch("result mismatch", exp, got);
      end
    end
  end

  // Watchdog: too long with no transaction accepted on either side.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb_flow_byte_accounting_top_k: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t    rows[$];
  ranked_flow_t picks[$];
  ranked_flow_t pool_key[$];

  function automatic stim_row_t row(logic m, logic [31:0] s, logic [31:0] d,
                                    logic [15:0] sp, logic [15:0] dp, logic [15:0] len);
    stim_row_t t;
    t.mode = m; t.src = s; t.dst = d; t.sport = sp; t.dport = dp; t.len = len;
    t.has_exp = 1'b0;
    t.exp = '{default: '0};
    return t;
  endfunction

  initial begin
    stim_row_t    t;
    ranked_flow_t pf;
    int           nrep;
    int           npool;
    bit           burst;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, extremes, hit with zero length, ties, ignored tick fields.
    rows = {rows, row(MODE_TICK, '1, '1, '1, '1, '1)};              // empty table: nothing
    rows = {rows, row(MODE_REPORT, '1, '1, '1, '1, 16'hFFFF)};
    rows = {rows, row(MODE_REPORT, '1, '1, '1, '1, 16'h0000)};      // hit, zero length
    rows = {rows, row(MODE_REPORT, '1, '1, '1, '1, 16'hFFFF)};
    t = row(MODE_TICK, '0, '0, '0, '0, '0);
    t.has_exp = 1'b1;
    t.exp = '{3'd1, '1, '1, '1, '1, 32'h0001_FFFE, 16'h0, 1'b1};
    rows = {rows, t};
    rows = {rows, row(MODE_REPORT, '0, '0, '0, '0, 16'h0000)};      // new flow at zero
    rows = {rows, row(MODE_REPORT, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 16'd100)};
    rows = {rows, row(MODE_REPORT, 32'h0A00_0003, 32'h0A00_0004, 16'd53, 16'd53, 16'd100)};
    rows = {rows, row(MODE_REPORT, 32'hFFFF_0000, 32'h0000_FFFF, 16'hFF00, 16'h00FF,
                      16'd300)};
    rows = {rows, row(MODE_REPORT, 32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001,
                      16'd100)};
    rows = {rows, row(MODE_REPORT, 32'h0A00_0005, 32'h0A00_0006, 16'd1, 16'd2, 16'd50)};
    rows = {rows, row(MODE_REPORT, 32'h0A00_0007, 32'h0A00_0008, 16'd3, 16'd4, 16'd100)};
    rows = {rows, row(MODE_REPORT, 32'h0A00_0001, 32'h0A00_0002, 16'd443, 16'd80, 16'd7)};
    rows = {rows, row(MODE_TICK, 32'h1234_5678, '1, 16'hAAAA, 16'h5555, 16'hFFFF)};
    rows = {rows, row(MODE_TICK, '0, '0, '0, '0, '0)};              // empty again
    rows = {rows, row(MODE_REPORT, 32'h0102_0304, 32'h0506_0708, 16'd9, 16'd10, 16'd1)};
    rows = {rows, row(MODE_TICK, '0, '0, '0, '0, '0)};

    foreach (rows[i]) begin
      send_txn(rows[i].mode, rows[i].src, rows[i].dst, rows[i].sport, rows[i].dport,
               rows[i].len, picks);
      if (rows[i].has_exp && (picks.size() == 0 || !same_flow(rows[i].exp, picks[0])))
        note_mismatch("directed prediction", rows[i].exp, (picks.size() != 0) ? picks[0] : t.exp);
      idle_for(pick_gap(1'b0));
    end

    // Random intervals: a small set of recurring flows plus stray new ones.
    while (n_sent < RAND_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      npool = $urandom_range(0, 8);
      pool_key.delete();
      for (int j = 0; j < npool; j++) begin
        pf.src = $urandom; pf.dst = $urandom;
        pf.sport = 16'($urandom); pf.dport = 16'($urandom);
        pool_key = {pool_key, pf};
      end
      nrep = (npool == 0) ? $urandom_range(0, 3) : $urandom_range(3, 25);
      for (int j = 0; j < nrep; j++) begin
        if (npool > 0 && $urandom_range(0, 9) < 8) pf = pool_key[$urandom_range(0, npool - 1)];
        else begin
          pf.src = $urandom; pf.dst = $urandom;
          pf.sport = 16'($urandom); pf.dport = 16'($urandom);
        end
        send_txn(MODE_REPORT, pf.src, pf.dst, pf.sport, pf.dport, pick_len(), picks);
        idle_for(pick_gap(burst));
      end
      send_txn(MODE_TICK, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
               picks);
      idle_for(pick_gap(burst));
    end

    // Hold off until the whole report has come back.
    idle_for(1);
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (!failed && mismatches == 0) begin
      $display("tb_flow_byte_accounting_top_k: clean");
    end else begin
      $display("tb_flow_byte_accounting_top_k: errors");
    end
    $finish;
  end
endmodule
